// File: rtl/core/pngss_pkg.sv
`timescale 1ns / 1ps
package pngss_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SIG,
    ERR_LONG,
    ERR_TRUNC
  } err_t;

  // 8-byte file signature, first byte at index 0
  localparam logic [7:0] PNG_SIG [0:7] = '{
    8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
  };

  localparam int SIG_LEN    = 8;
  localparam int FIELD_LEN  = 4;  // length, type and CRC fields
  localparam int MIN_IMAGE  = SIG_LEN + 3 * FIELD_LEN;  // signature + empty chunk

  // Tag for one byte, produced by the parser
  typedef struct packed {
    logic [15:0] image_index;
    logic        image_last;
    logic [31:0] image_size;
    err_t        error_code;
  } tag_t;

endpackage

// File: rtl/core/png_sequence_splitter_unit.sv
`timescale 1ns / 1ps
// Splits a byte stream of back-to-back PNG images and tags every byte.
// Input channel in_*: one stream byte per word, in_tlast marks the last byte
// of the whole stream. Output channel out_*: the same byte with its image
// number, running image size and error code; out_tlast marks the final CRC
// byte of an image. Every input word yields exactly one output word.
// Configuration: cfg_wr_en writes cfg_wr_data as the largest accepted chunk
// data length; write it only while no words are in flight.
// A word accepted is registered into the input stage, then parsed and
// registered into the output stage once that stage is empty or draining,
// where it drives out_tvalid until out_tready takes it.
// Throughput is one word per cycle while out_tready stays high; the parse
// state (phase, position, counters) updates once per word as it moves from
// the input to the output register.
// Errors (bad signature, chunk too long, stream cut inside an image) are
// held until reset: later words still pass through with the stored code.
// Reset (rst_n low at a clock edge) empties both stages, restarts parsing
// at the signature, clears image number, size and error, and sets the
// length limit to its maximum. When out_tready is low the output word
// holds, the input stage still fills once, then in_tready drops.
module png_sequence_splitter_unit #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data,   // max_chunk_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tlast,      // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // [7:0] out_byte, [23:8] image_index,
                                     // [55:24] image_size, [57:56] error_code,
                                     // [63:58] zero
  output logic        out_tlast      // image_last
);
  import pngss_pkg::*;

  logic [30:0] max_len_r;

  // input stage
  logic       s0_valid_r, s0_valid_nxt;
  logic [7:0] s0_byte_r;
  logic       s0_end_r;

  // output stage
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  tag_t        out_tag_r;

  logic in_acc;
  logic advance;
  tag_t tag;

  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_acc) s0_valid_nxt = 1'b1;
    else if (advance) s0_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= 31'h7FFF_FFFF;
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_byte_r <= in_tdata;
      s0_end_r  <= in_tlast;
    end
    if (advance) begin
      out_byte_r <= s0_byte_r;
      out_tag_r  <= tag;
    end
  end

  pngss_parser #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (s0_byte_r),
    .stream_end (s0_end_r),
    .max_len    (max_len_r),
    .tag        (tag)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_tag_r.image_last;
  assign out_tdata  = {6'b0, out_tag_r.error_code, out_tag_r.image_size,
                       out_tag_r.image_index, out_byte_r};

  // an image end never carries an error
  a_last_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[57:56] == 2'd0)
    else $error("image end reported with error code");

  // smallest image is a signature plus one empty chunk
  a_last_min_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[55:24] >= 32'(MIN_IMAGE))
    else $error("image end reported below minimum image size");

  // a held input word stays put while the output stage is blocked
  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !advance |=> s0_valid_r && $stable(s0_byte_r) && $stable(s0_end_r))
    else $error("input stage lost a word while stalled");

  // an empty output stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output stage");

endmodule

// File: rtl/core/pngss_parser.sv
`timescale 1ns / 1ps
module pngss_parser #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,         // commit one byte
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  input  logic [30:0]        max_len,
  output pngss_pkg::tag_t    tag
);
  import pngss_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic [30:0]              pos_r, pos_nxt;
  logic [31:0]              chunk_len_r, chunk_len_nxt;
  logic [INDEX_WIDTH-1:0]   image_cnt_r, image_cnt_nxt;
  logic [31:0]              size_r, size_nxt;
  err_t                     sticky_r, sticky_nxt;

  logic [30:0] pos_inc;
  logic [31:0] len_shift;
  logic [31:0] size_inc;
  logic [31:0] idx_wide;
  logic        last;
  err_t        err;

  assign pos_inc   = pos_r + 31'd1;
  assign len_shift = {chunk_len_r[23:0], data_byte};
  assign size_inc  = (size_r == 32'hFFFF_FFFF) ? size_r : size_r + 32'd1;
  assign idx_wide  = 32'(image_cnt_r);

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    chunk_len_nxt = chunk_len_r;
    image_cnt_nxt = image_cnt_r;
    size_nxt      = size_r;
    sticky_nxt    = sticky_r;
    last          = 1'b0;
    err           = ERR_NONE;

    if (sticky_r != ERR_NONE) begin
      err = sticky_r;
    end else begin
      size_nxt = size_inc;
      unique case (phase_r)
        PH_SIG: begin
          if (data_byte != PNG_SIG[pos_r[2:0]]) begin
            err = ERR_SIG;
          end else if (pos_r == 31'(SIG_LEN - 1)) begin
            pos_nxt       = '0;
            chunk_len_nxt = '0;
            phase_nxt     = PH_LEN;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_LEN: begin
          chunk_len_nxt = len_shift;
          pos_nxt       = pos_inc;
          if (pos_r == 31'(FIELD_LEN - 1)) begin
            pos_nxt = '0;
            if (len_shift > {1'b0, max_len}) err = ERR_LONG;
            else phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          pos_nxt = pos_inc;
          if (pos_r == 31'(FIELD_LEN - 1)) begin
            pos_nxt   = '0;
            phase_nxt = (chunk_len_r == '0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          pos_nxt = pos_inc;
          if ({1'b0, pos_inc} >= chunk_len_r) begin
            pos_nxt   = '0;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          pos_nxt = pos_inc;
          if (pos_r == 31'(FIELD_LEN - 1)) begin
            pos_nxt = '0;
            if (chunk_len_r == '0) begin
              last      = 1'b1;
              phase_nxt = PH_SIG;
            end else begin
              chunk_len_nxt = '0;
              phase_nxt     = PH_LEN;
            end
          end
        end
        default: begin
          phase_nxt = PH_SIG;
          pos_nxt   = '0;
        end
      endcase

      if (err == ERR_NONE && stream_end && !last) err = ERR_TRUNC;

      if (err != ERR_NONE) begin
        sticky_nxt = err;
        last       = 1'b0;
      end else if (last) begin
        image_cnt_nxt = image_cnt_r + INDEX_WIDTH'(1);
        size_nxt      = '0;
      end
    end
  end

  // frozen counters read out directly once an error is held
  assign tag.image_index = idx_wide[15:0];
  assign tag.image_last  = last;
  assign tag.image_size  = (sticky_r != ERR_NONE) ? size_r : size_inc;
  assign tag.error_code  = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      pos_r       <= '0;
      chunk_len_r <= '0;
      image_cnt_r <= '0;
      size_r      <= '0;
      sticky_r    <= ERR_NONE;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      chunk_len_r <= chunk_len_nxt;
      image_cnt_r <= image_cnt_nxt;
      size_r      <= size_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

endmodule
